FILE: rtl/core/wps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wps_pkg;

  localparam int PATTERN_MAX_DEF = 64;
  localparam int OFFSET_BITS_DEF = 32;

  localparam int LEN_W   = 7;
  localparam int IDX_W   = 6;
  localparam int BYTE_W  = 8;
  localparam int COUNT_W = 32;
  localparam int OFS_W   = 32;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_STREAM = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_INVALID   = 2'd0,
    ST_MISSING   = 2'd1,
    ST_UNIQUE    = 2'd2,
    ST_AMBIGUOUS = 2'd3
  } scan_status_t;

  typedef struct packed {
    cmd_t               command;
    logic [IDX_W-1:0]   pattern_index;
    logic [BYTE_W-1:0]  pattern_value;
    logic               pattern_wildcard;
    logic [BYTE_W-1:0]  image_byte;
    logic               last_byte;
  } in_item_t;

  typedef struct packed {
    scan_status_t       scan_status;
    logic [OFS_W-1:0]   first_offset;
    logic [COUNT_W-1:0] match_count;
  } out_item_t;

  // one streamed byte handed from the compare stage to the tally stage
  typedef struct packed {
    logic valid;
    logic last;
    logic hit;
  } scan_flags_t;

  function automatic logic length_ok(logic [LEN_W-1:0] len, int pmax);
    return (len != '0) && (int'(len) <= pmax);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/wps_match.sv
`timescale 1ns / 1ps
`default_nettype none

module wps_match #(
  parameter int PATTERN_MAX = wps_pkg::PATTERN_MAX_DEF,
  parameter int OFFSET_BITS = wps_pkg::OFFSET_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire wps_pkg::in_item_t            in_data,
  input  wire logic [wps_pkg::LEN_W-1:0]    pattern_length,
  input  wire logic                         tally_ready,
  output wps_pkg::scan_flags_t              flags,
  output logic [OFFSET_BITS-1:0]            match_pos
);

  localparam int IW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int SW = $clog2(PATTERN_MAX + 1);

  // input register
  logic                 s1_valid_r;
  wps_pkg::in_item_t    s1_data_r;

  // image state and signature store
  logic [wps_pkg::BYTE_W-1:0] win_r     [PATTERN_MAX];
  logic [wps_pkg::BYTE_W-1:0] win_nxt   [PATTERN_MAX];
  logic [wps_pkg::BYTE_W-1:0] sig_val_r [PATTERN_MAX];
  logic                       sig_wild_r[PATTERN_MAX];
  logic [OFFSET_BITS-1:0]     bs_r;
  logic [OFFSET_BITS-1:0]     bs_nxt;

  // compare stage register
  wps_pkg::scan_flags_t       flags_r;
  logic [OFFSET_BITS-1:0]     pos_r;

  logic                       s2_adv;
  logic                       s1_move;
  logic                       is_stream;
  logic                       is_load;
  logic                       len_good;
  logic [SW-1:0]              sh;
  logic [wps_pkg::BYTE_W-1:0] shf [SW+1][PATTERN_MAX];
  logic                       all_eq;
  logic                       hit_nxt;
  logic [OFFSET_BITS-1:0]     pos_nxt;
  logic [OFFSET_BITS-1:0]     len_ext;
  logic [7:0]                 idx8;
  logic                       idx_ok;

  assign s2_adv    = !flags_r.valid || tally_ready;
  assign s1_move   = s1_valid_r && s2_adv;
  assign in_stall  = s1_valid_r && !s2_adv;
  assign is_stream = (s1_data_r.command == wps_pkg::CMD_STREAM);
  assign is_load   = (s1_data_r.command == wps_pkg::CMD_LOAD);
  assign len_good  = wps_pkg::length_ok(pattern_length, PATTERN_MAX);
  assign len_ext   = OFFSET_BITS'(pattern_length);
  assign idx8      = 8'(s1_data_r.pattern_index);
  assign idx_ok    = int'(s1_data_r.pattern_index) < PATTERN_MAX;

  always_comb begin
    win_nxt[0] = s1_data_r.image_byte;
    for (int k = 1; k < PATTERN_MAX; k++) begin
      win_nxt[k] = win_r[k-1];
    end
    bs_nxt = (bs_r == '1) ? bs_r : bs_r + 1'b1;
  end

  // line the candidate up with the signature: oldest byte of the candidate at index 0
  always_comb begin
    sh = len_good ? SW'(PATTERN_MAX - int'(pattern_length)) : '0;
    for (int k = 0; k < PATTERN_MAX; k++) begin
      shf[0][k] = win_nxt[PATTERN_MAX-1-k];
    end
    for (int s = 0; s < SW; s++) begin
      for (int k = 0; k < PATTERN_MAX; k++) begin
        shf[s+1][k] = shf[s][k];
        if (sh[s]) begin
          if (k + (1 << s) < PATTERN_MAX) begin
            shf[s+1][k] = shf[s][k + (1 << s)];
          end else begin
            shf[s+1][k] = '0;
          end
        end
      end
    end
  end

  always_comb begin
    all_eq = 1'b1;
    for (int j = 0; j < PATTERN_MAX; j++) begin
      if (j < int'(pattern_length) && !sig_wild_r[j] && shf[SW][j] != sig_val_r[j]) begin
        all_eq = 1'b0;
      end
    end
    hit_nxt = len_good && (bs_nxt >= len_ext) && all_eq;
    pos_nxt = bs_nxt - len_ext;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid_r <= 1'b1;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && is_load && idx_ok) begin
      sig_val_r[idx8[IW-1:0]]  <= s1_data_r.pattern_value;
      sig_wild_r[idx8[IW-1:0]] <= s1_data_r.pattern_wildcard;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < PATTERN_MAX; k++) begin
        win_r[k] <= '0;
      end
      bs_r    <= '0;
      flags_r <= '0;
    end else begin
      if (s1_move && is_stream) begin
        // the image ends here: start the next one from a clean window
        for (int k = 0; k < PATTERN_MAX; k++) begin
          win_r[k] <= s1_data_r.last_byte ? '0 : win_nxt[k];
        end
        bs_r          <= s1_data_r.last_byte ? '0 : bs_nxt;
        flags_r.valid <= 1'b1;
        flags_r.last  <= s1_data_r.last_byte;
        flags_r.hit   <= hit_nxt;
      end else if (s2_adv) begin
        flags_r.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && is_stream) begin
      pos_r <= pos_nxt;
    end
  end

  assign flags     = flags_r;
  assign match_pos = pos_r;

endmodule

`default_nettype wire

FILE: rtl/core/wps_tally.sv
`timescale 1ns / 1ps
`default_nettype none

module wps_tally #(
  parameter int PATTERN_MAX = wps_pkg::PATTERN_MAX_DEF,
  parameter int OFFSET_BITS = wps_pkg::OFFSET_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [wps_pkg::LEN_W-1:0]    pattern_length,
  input  wire wps_pkg::scan_flags_t         flags,
  input  wire logic [OFFSET_BITS-1:0]       match_pos,
  output logic                              tally_ready,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output wps_pkg::out_item_t                out_data
);

  logic [wps_pkg::COUNT_W-1:0] cnt_r;
  logic [wps_pkg::COUNT_W-1:0] cnt_nxt;
  logic [OFFSET_BITS-1:0]      first_r;
  logic [OFFSET_BITS-1:0]      first_nxt;
  logic                        out_valid_r;
  wps_pkg::out_item_t          out_data_r;
  wps_pkg::out_item_t          res_nxt;
  logic                        out_free;
  logic                        take;
  logic [63:0]                 first_ext;

  assign out_free    = !out_valid_r || !out_stall;
  assign tally_ready = !flags.last || out_free;
  assign take        = flags.valid && tally_ready;

  always_comb begin
    cnt_nxt   = cnt_r;
    first_nxt = first_r;
    if (flags.hit) begin
      if (cnt_r == '0) begin
        first_nxt = match_pos;
      end
      if (cnt_r != '1) begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
    first_ext = 64'(first_nxt);

    res_nxt.first_offset = (cnt_nxt != '0) ? first_ext[wps_pkg::OFS_W-1:0] : '0;
    res_nxt.match_count  = cnt_nxt;
    priority if (!wps_pkg::length_ok(pattern_length, PATTERN_MAX)) begin
      res_nxt.scan_status  = wps_pkg::ST_INVALID;
      res_nxt.first_offset = '0;
      res_nxt.match_count  = '0;
    end else if (cnt_nxt == '0) begin
      res_nxt.scan_status = wps_pkg::ST_MISSING;
    end else if (cnt_nxt == wps_pkg::COUNT_W'(1)) begin
      res_nxt.scan_status = wps_pkg::ST_UNIQUE;
    end else begin
      res_nxt.scan_status = wps_pkg::ST_AMBIGUOUS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      first_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        // per-image counters start over after the last byte
        cnt_r   <= flags.last ? '0 : cnt_nxt;
        first_r <= flags.last ? '0 : first_nxt;
      end
      if (take && flags.last) begin
        out_valid_r <= 1'b1;
      end else if (out_free) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && flags.last) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

FILE: rtl/core/wildcard_pattern_scan.sv
// Wildcard byte-signature scanner.
// Input channel (in_valid / in_stall / in_data): each request either loads one
// signature entry (value plus wildcard bit) or streams one image byte, the
// final byte of an image carrying last_byte. A request is taken on a clock edge
// with in_valid high and in_stall low.
// Config channel (cfg_valid / cfg_ready / cfg_data): writes pattern_length; it
// is always ready and should only be written while no request is in flight.
// Result channel (out_valid / out_stall / out_data): one result per image,
// carrying status, first match offset and saturating match count.
// Throughput: one request per cycle while in_stall is low. A last byte taken
// passes the input register, window compare and result register to out_valid.
// The cycle time is set by the window alignment shifter and the parallel
// compare over all signature positions.
// When out_stall holds a result, the two internal stages keep filling, then
// in_stall rises; nothing is dropped.
// Reset clears the window, the per-image counters, pattern_length and all
// valid flags; signature entries hold garbage until loaded.
`timescale 1ns / 1ps
`default_nettype none

module wildcard_pattern_scan #(
  parameter int PATTERN_MAX = wps_pkg::PATTERN_MAX_DEF,
  parameter int OFFSET_BITS = wps_pkg::OFFSET_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire wps_pkg::in_item_t          in_data,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output wps_pkg::out_item_t              out_data,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [wps_pkg::LEN_W-1:0]  cfg_data
);

  logic [wps_pkg::LEN_W-1:0] len_r;
  wps_pkg::scan_flags_t      flags;
  logic [OFFSET_BITS-1:0]    match_pos;
  logic                      tally_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      len_r <= cfg_data;
    end
  end

  wps_match #(
    .PATTERN_MAX (PATTERN_MAX),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_match (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .pattern_length (len_r),
    .tally_ready    (tally_ready),
    .flags          (flags),
    .match_pos      (match_pos)
  );

  wps_tally #(
    .PATTERN_MAX (PATTERN_MAX),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_tally (
    .clk            (clk),
    .rst_n          (rst_n),
    .pattern_length (len_r),
    .flags          (flags),
    .match_pos      (match_pos),
    .tally_ready    (tally_ready),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data)
  );

`ifndef NO_ASSERTIONS
  a_invalid_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.scan_status == wps_pkg::ST_INVALID |->
      out_data.match_count == '0 && out_data.first_offset == '0)
    else $error("invalid status with non-zero count or offset");

  a_missing_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.scan_status == wps_pkg::ST_MISSING |->
      out_data.match_count == '0 && out_data.first_offset == '0)
    else $error("missing status with non-zero count or offset");

  a_unique_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.scan_status == wps_pkg::ST_UNIQUE |->
      out_data.match_count == wps_pkg::COUNT_W'(1))
    else $error("unique status without exactly one match");

  a_ambig_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.scan_status == wps_pkg::ST_AMBIGUOUS |->
      out_data.match_count > wps_pkg::COUNT_W'(1))
    else $error("ambiguous status with fewer than two matches");
`endif

endmodule

`default_nettype wire

FILE: sim/tb.sv
`timescale 1ns / 1ps

module tb;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_stall;
  wps_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  wps_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [wps_pkg::LEN_W-1:0] cfg_data = '0;

  wildcard_pattern_scan uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // requests waiting to be offered, and scan results still owed by the block
  wps_pkg::in_item_t pending[$];
  wps_pkg::out_item_t scan_results_due[$];

  int errors = 0;
  int results_done = 0;
  int queued_items = 0;
  int cyc = 0;
  int hold_left = 0;
  logic hold_used = 1'b0;

  // predictor state
  logic [wps_pkg::LEN_W-1:0] cur_length = '0;
  logic [wps_pkg::BYTE_W-1:0] win [wps_pkg::PATTERN_MAX_DEF];
  logic [wps_pkg::BYTE_W-1:0] sig_value [wps_pkg::PATTERN_MAX_DEF];
  logic sig_wild [wps_pkg::PATTERN_MAX_DEF];
  logic [wps_pkg::OFS_W-1:0] img_len;
  logic [wps_pkg::COUNT_W-1:0] hit_count;
  logic [wps_pkg::OFS_W-1:0] first_hit;

  // stimulus side copy of the signature, used to plant matches
  logic [wps_pkg::BYTE_W-1:0] gen_value [wps_pkg::PATTERN_MAX_DEF];
  logic gen_wild [wps_pkg::PATTERN_MAX_DEF];
  logic loaded [wps_pkg::PATTERN_MAX_DEF];

  logic quiet;
  assign quiet = (cyc >= 1000) && (cyc < 2000);

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  function automatic logic len_valid();
    return (cur_length >= 1) && (cur_length <= wps_pkg::PATTERN_MAX_DEF);
  endfunction

  task automatic clear_image();
    int k;
    for (k = 0; k < wps_pkg::PATTERN_MAX_DEF; k++) win[k] = '0;
    img_len = '0;
    hit_count = '0;
    first_hit = '0;
  endtask

  task automatic scan_step(wps_pkg::in_item_t it);
    wps_pkg::out_item_t r;
    logic hit;
    int k;
    if (it.command == wps_pkg::CMD_LOAD) begin
      sig_value[it.pattern_index] = it.pattern_value;
      sig_wild[it.pattern_index] = it.pattern_wildcard;
      return;
    end
    for (k = wps_pkg::PATTERN_MAX_DEF - 1; k > 0; k--) win[k] = win[k-1];
    win[0] = it.image_byte;
    if (img_len != '1) img_len++;
    if (len_valid() && img_len >= cur_length) begin
      hit = 1'b1;
      // oldest byte of the candidate sits at window index length-1
      for (k = 0; k < cur_length; k++) begin
        if (!sig_wild[k] && win[cur_length - 1 - k] != sig_value[k]) hit = 1'b0;
      end
      if (hit) begin
        if (hit_count == 0) first_hit = img_len - cur_length;
        if (hit_count != '1) hit_count++;
      end
    end
    if (!it.last_byte) return;
    r = '0;
    if (len_valid()) begin
      r.scan_status = (hit_count == 0) ? wps_pkg::ST_MISSING :
                      (hit_count == 1) ? wps_pkg::ST_UNIQUE : wps_pkg::ST_AMBIGUOUS;
      r.first_offset = (hit_count != 0) ? first_hit : '0;
      r.match_count = hit_count;
    end else begin
      r.scan_status = wps_pkg::ST_INVALID;
    end
    scan_results_due.push_back(r);
    clear_image();
  endtask

  always @(posedge clk) begin
    cyc <= cyc + 1;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) scan_step(in_data);
      if (!in_valid || !in_stall) begin
        if (pending.size() != 0 &&
            (quiet || hold_left != 0 || $urandom_range(0, 99) >= 28)) begin
          in_data <= pending.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall, with one long hold-off to back the block up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= (hold_left != 1);
    end else if (!hold_used && results_done >= 20) begin
      hold_used <= 1'b1;
      hold_left <= 400;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(0, 99) < 28);
    end
  end

  // monitor
  always @(posedge clk) begin : mon
    wps_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (scan_results_due.size() == 0) begin
        report_mismatch("unexpected result, status", out_data.scan_status, 0);
      end else begin
        want = scan_results_due.pop_front();
        if (out_data.scan_status !== want.scan_status)
          report_mismatch("scan_status", out_data.scan_status, want.scan_status);
        if (out_data.first_offset !== want.first_offset)
          report_mismatch("first_offset", out_data.first_offset, want.first_offset);
        if (out_data.match_count !== want.match_count)
          report_mismatch("match_count", out_data.match_count, want.match_count);
      end
      results_done <= results_done + 1;
    end
  end

  task automatic queue_load(int idx, logic [wps_pkg::BYTE_W-1:0] val, logic wild);
    wps_pkg::in_item_t it;
    it.command = wps_pkg::CMD_LOAD;
    it.pattern_index = wps_pkg::IDX_W'(idx);
    it.pattern_value = val;
    it.pattern_wildcard = wild;
    it.image_byte = wps_pkg::BYTE_W'($urandom_range(0, 255));
    it.last_byte = 1'($urandom_range(0, 1));
    pending.push_back(it);
    gen_value[idx] = val;
    gen_wild[idx] = wild;
    loaded[idx] = 1'b1;
    queued_items++;
  endtask

  task automatic queue_byte(logic [wps_pkg::BYTE_W-1:0] b, logic last);
    wps_pkg::in_item_t it;
    it.command = wps_pkg::CMD_STREAM;
    it.pattern_index = wps_pkg::IDX_W'($urandom_range(0, 63));
    it.pattern_value = wps_pkg::BYTE_W'($urandom_range(0, 255));
    it.pattern_wildcard = 1'($urandom_range(0, 1));
    it.image_byte = b;
    it.last_byte = last;
    pending.push_back(it);
    queued_items++;
  endtask

  task automatic queue_noise_load();
    queue_load(int'($urandom_range(0, 63)), wps_pkg::BYTE_W'($urandom_range(0, 255)),
               $urandom_range(0, 3) == 0);
  endtask

  // random fill, then the signature planted a few times (possibly overlapping)
  task automatic queue_image(int n, int embeds, int noise_pct);
    logic [wps_pkg::BYTE_W-1:0] img [$];
    int j, k, p;
    for (j = 0; j < n; j++) begin
      if ($urandom_range(0, 99) < 30) img.push_back(gen_value[$urandom_range(0, 63)]);
      else img.push_back(wps_pkg::BYTE_W'($urandom_range(0, 255)));
    end
    if (len_valid() && cur_length <= n) begin
      for (k = 0; k < embeds; k++) begin
        p = int'($urandom_range(0, n - cur_length));
        for (j = 0; j < cur_length; j++)
          img[p + j] = gen_wild[j] ? wps_pkg::BYTE_W'($urandom_range(0, 255)) : gen_value[j];
      end
    end
    for (j = 0; j < n; j++) begin
      if ($urandom_range(0, 99) < noise_pct) queue_noise_load();
      queue_byte(img[j], j == n - 1);
    end
  endtask

  // wait for the block to drain, including trailing loads that give no result
  task automatic settle();
    do @(negedge clk);
    while (pending.size() != 0 || in_valid || scan_results_due.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_length(logic [wps_pkg::LEN_W-1:0] v);
    settle();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_length = v;
    @(negedge clk);
  endtask

  initial begin : stimulus
    int k, guard, target, mark, phase, n;
    logic [wps_pkg::LEN_W-1:0] len;
    clear_image();
    for (k = 0; k < wps_pkg::PATTERN_MAX_DEF; k++) begin
      sig_value[k] = '0;
      sig_wild[k] = 1'b0;
      gen_value[k] = '0;
      gen_wild[k] = 1'b0;
      loaded[k] = 1'b0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // length still zero after reset: invalid signature
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h5A, 1'b1);

    write_length(wps_pkg::LEN_W'(3));
    queue_load(0, 8'hFF, 1'b0);
    queue_load(1, 8'h00, 1'b1);
    queue_load(2, 8'h00, 1'b0);
    queue_load(63, 8'hFF, 1'b1);
    // image shorter than the signature
    queue_byte(8'hFF, 1'b1);
    // single match at offset zero
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h37, 1'b0);
    queue_byte(8'h00, 1'b1);
    // two matches, first at offset one
    queue_byte(8'h11, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b1);
    // signature rewritten in the middle of an image
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h01, 1'b0);
    queue_load(2, 8'h01, 1'b0);
    queue_byte(8'h01, 1'b1);
    // no match at all
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b1);

    // length beyond the window
    write_length(wps_pkg::LEN_W'(127));
    queue_byte(8'hAA, 1'b1);

    phase = 0;
    while (queued_items < 2000) begin
      case (phase)
        0: len = wps_pkg::LEN_W'(1);
        1: len = wps_pkg::LEN_W'(wps_pkg::PATTERN_MAX_DEF);
        2: len = '0;
        3: len = wps_pkg::LEN_W'(wps_pkg::PATTERN_MAX_DEF + 1);
        default: begin
          k = int'($urandom_range(0, 99));
          if (k < 8) len = '0;
          else if (k < 14) len = wps_pkg::LEN_W'(wps_pkg::PATTERN_MAX_DEF);
          else if (k < 20)
            len = wps_pkg::LEN_W'($urandom_range(wps_pkg::PATTERN_MAX_DEF + 1, 127));
          else if (k < 50) len = wps_pkg::LEN_W'($urandom_range(1, 4));
          else len = wps_pkg::LEN_W'($urandom_range(1, 16));
        end
      endcase
      phase++;
      write_length(len);
      if (len_valid()) begin
        // every compared entry must have been loaded at some point
        for (k = 0; k < cur_length; k++) begin
          if (!loaded[k] || $urandom_range(0, 1) == 1)
            queue_load(k, wps_pkg::BYTE_W'($urandom_range(0, 255)),
                       $urandom_range(0, 4) == 0);
        end
      end
      target = int'($urandom_range(80, 200));
      mark = queued_items;
      while (queued_items - mark < target) begin
        k = int'($urandom_range(0, 99));
        if (k < 8) begin
          queue_noise_load();
        end else if (len_valid() && k < 85) begin
          n = int'($urandom_range(1, 2 * cur_length + 6));
          queue_image(n, int'($urandom_range(0, 3)), 3);
        end else begin
          queue_image(int'($urandom_range(1, 12)), 0, 15);
        end
      end
    end

    for (guard = 0; guard < 5000 &&
         (pending.size() != 0 || in_valid || scan_results_due.size() != 0); guard++)
      @(negedge clk);
    repeat (10) @(negedge clk);
    if (scan_results_due.size() != 0)
      report_mismatch("results never delivered, count", scan_results_due.size(), 0);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
